// ===== src/qep_pkg.sv =====
package qep_pkg;

  localparam int unsigned POS_W   = 8;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LIMIT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIMIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_STEP = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] min_limit;
    logic [POS_W-1:0] max_limit;
    logic [CNT_W-1:0] ticks_per_step;
  } qep_cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] last_phase;
    logic [CNT_W-1:0]   fwd_cnt;
    logic [CNT_W-1:0]   bwd_cnt;
    logic [POS_W-1:0]   position;
  } qep_state_t;

  typedef struct packed {
    logic             moved;
    logic [POS_W-1:0] position;
  } qep_result_t;

  // Gray sequence forward: 0 -> 2 -> 3 -> 1 -> 0
  function automatic logic [PHASE_W-1:0] fwd_next(input logic [PHASE_W-1:0] ph);
    logic [PHASE_W-1:0] r;
    case (ph)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      2'd2:    r = 2'd3;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  // Gray sequence backward: 0 -> 1 -> 3 -> 2 -> 0
  function automatic logic [PHASE_W-1:0] bwd_next(input logic [PHASE_W-1:0] ph);
    logic [PHASE_W-1:0] r;
    case (ph)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd3;
      2'd2:    r = 2'd0;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

// ===== src/qep_step.sv =====
module qep_step import qep_pkg::*; (
  input  logic [PHASE_W-1:0] phase,
  input  qep_state_t         st,
  input  qep_cfg_t           cfg,
  output qep_state_t         st_nxt,
  output qep_result_t        res
);

  logic             changed;
  logic             fwd_hit;
  logic             bwd_hit;
  logic [CNT_W-1:0] fwd_inc;
  logic [CNT_W-1:0] bwd_inc;
  logic             step_up;
  logic             step_dn;
  logic [POS_W-1:0] pos_up;
  logic [POS_W-1:0] pos_dn;

  always_comb begin
    changed = (phase != st.last_phase);
    fwd_hit = changed && (phase == fwd_next(st.last_phase));
    bwd_hit = changed && !fwd_hit && (phase == bwd_next(st.last_phase));

    fwd_inc = st.fwd_cnt + CNT_W'(fwd_hit);
    bwd_inc = st.bwd_cnt + CNT_W'(bwd_hit);

    // both counts are checked on any phase change, even a two-bit jump
    step_up = changed && (fwd_inc == cfg.ticks_per_step);
    step_dn = changed && (bwd_inc == cfg.ticks_per_step);

    // up applied first, then down
    if (!step_up) begin
      pos_up = st.position;
    end else if (st.position >= cfg.max_limit) begin
      pos_up = cfg.max_limit;
    end else begin
      pos_up = st.position + POS_W'(1);
    end

    if (!step_dn) begin
      pos_dn = pos_up;
    end else if (pos_up <= cfg.min_limit) begin
      pos_dn = cfg.min_limit;
    end else begin
      pos_dn = pos_up - POS_W'(1);
    end

    st_nxt.last_phase = phase;
    st_nxt.fwd_cnt    = step_up ? '0 : fwd_inc;
    st_nxt.bwd_cnt    = step_dn ? '0 : bwd_inc;
    st_nxt.position   = pos_dn;

    res.moved    = step_up || step_dn;
    res.position = pos_dn;
  end

endmodule

// ===== src/qep_out_buf.sv =====
module qep_out_buf import qep_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  qep_result_t push_data,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output qep_result_t out_data
);

  logic        out_vld_r, out_vld_nxt;
  logic        skid_vld_r, skid_vld_nxt;
  qep_result_t out_data_r, out_data_nxt;
  qep_result_t skid_data_r, skid_data_nxt;
  logic        out_free;

  always_comb begin
    out_free      = !out_vld_r || !out_stall;
    out_vld_nxt   = out_vld_r;
    skid_vld_nxt  = skid_vld_r;
    out_data_nxt  = out_data_r;
    skid_data_nxt = skid_data_r;
    if (out_free) begin
      // skid is full only while push is held off
      out_vld_nxt  = skid_vld_r || push;
      out_data_nxt = skid_vld_r ? skid_data_r : push_data;
      skid_vld_nxt = 1'b0;
    end else if (push) begin
      skid_vld_nxt  = 1'b1;
      skid_data_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/quadrature_encoder_position_core.sv =====
// Quadrature encoder position counter. Each input transaction is one sample
// of encoder pins A and B; each sample yields exactly one output transaction
// carrying the position after the update and a moved flag. Forward Gray
// steps (0,2,3,1) and backward steps (0,1,3,2) feed separate 8-bit counters;
// when either equals ticks_per_step it clears and the position moves one
// count, saturating at max_limit / min_limit. Throughput is one sample per
// clock while in_stall is low. Phase decode, count and limit compare are
// combinational from the state registers into the output register or, while
// that is stalled, into the skid entry. A two-entry output buffer lets one
// more sample in while a result is stalled; in_stall rises only when both
// entries are held. Write the cfg registers only while idle.
module quadrature_encoder_position_core import qep_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // sample channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_pin_a,
  input  logic                 in_pin_b,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_moved,
  output logic [POS_W-1:0]     out_position,
  // configuration writes
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  qep_cfg_t    cfg_r, cfg_nxt;
  qep_state_t  st_r, st_nxt;
  qep_result_t res;
  qep_result_t out_res;
  logic        buf_full;
  logic        in_acc;

  // config registers; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MIN_LIMIT:      cfg_nxt.min_limit      = cfg_wdata;
        CFG_MAX_LIMIT:      cfg_nxt.max_limit      = cfg_wdata;
        CFG_TICKS_PER_STEP: cfg_nxt.ticks_per_step = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_limit      <= '0;
      cfg_r.max_limit      <= '1;
      cfg_r.ticks_per_step <= CNT_W'(4);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = buf_full;
  assign in_acc   = in_valid && !buf_full;

  // phase decode, counters and saturating position update
  qep_step u_step (
    .phase  ({in_pin_b, in_pin_a}),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // tracking state only advances on an accepted sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  qep_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_moved    = out_res.moved;
  assign out_position = out_res.position;

  // a sample at the stored phase leaves all tracking state untouched
  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ({in_pin_b, in_pin_a} == st_r.last_phase) |=> st_r == $past(st_r))
    else $error("state changed on unchanged phase");

  // a completed step always clears at least one direction counter
  a_step_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res.moved |=> (st_r.fwd_cnt == '0) || (st_r.bwd_cnt == '0))
    else $error("step completed without clearing a counter");

  // an accepted sample always shows up as a pending result next cycle
  a_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid)
    else $error("accepted sample produced no result");

  // position moves by at most one count per sample unless pinned to a limit;
  // an up step clamped to max_limit followed by a down step lands one below it
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (st_r.position == $past(st_r.position)) ||
               (st_r.position == $past(st_r.position) + POS_W'(1)) ||
               (st_r.position == $past(st_r.position) - POS_W'(1)) ||
               (st_r.position == $past(cfg_r.max_limit)) ||
               (st_r.position == $past(cfg_r.max_limit) - POS_W'(1)) ||
               (st_r.position == $past(cfg_r.min_limit)))
    else $error("position jumped");

endmodule

// ===== tb/qep_result_checker.sv =====
`timescale 1ns / 100ps
module qep_result_checker import qep_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_pin_a,
  input  logic                 in_pin_b,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_moved,
  input  logic [POS_W-1:0]     out_position,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   outstanding,
  output int                   samples_checked,
  output int                   steps_seen
);

  localparam int PRINT_CAP = 25;

  qep_cfg_t           cfg_mirror;
  logic [PHASE_W-1:0] prev_phase;
  logic [CNT_W-1:0]   fwd_ticks;
  logic [CNT_W-1:0]   bwd_ticks;
  logic [POS_W-1:0]   pos_track;
  qep_result_t        expected_results[$];

  initial begin
    fail_count      = 0;
    outstanding     = 0;
    samples_checked = 0;
    steps_seen      = 0;
  end

  // one line per mismatch, printing capped so a broken block cannot flood the log
  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP) begin
      $display("%0t ns checker: %s", $time, msg);
    end
    fail_count++;
  endtask

  // forward Gray step: {b,a} -> {~a,b}; backward: {b,a} -> {a,~b}
  task automatic predict_sample(input logic [PHASE_W-1:0] ph);
    qep_result_t want;
    want.moved = 1'b0;
    if (ph != prev_phase) begin
      if (ph == {~prev_phase[0], prev_phase[1]}) begin
        fwd_ticks = fwd_ticks + 1'b1;
      end else if (ph == {prev_phase[0], ~prev_phase[1]}) begin
        bwd_ticks = bwd_ticks + 1'b1;
      end
      if (fwd_ticks == cfg_mirror.ticks_per_step) begin
        pos_track  = (pos_track >= cfg_mirror.max_limit) ? cfg_mirror.max_limit
                                                         : pos_track + 1'b1;
        fwd_ticks  = '0;
        want.moved = 1'b1;
      end
      if (bwd_ticks == cfg_mirror.ticks_per_step) begin
        pos_track  = (pos_track <= cfg_mirror.min_limit) ? cfg_mirror.min_limit
                                                         : pos_track - 1'b1;
        bwd_ticks  = '0;
        want.moved = 1'b1;
      end
      prev_phase = ph;
    end
    want.position = pos_track;
    expected_results.push_back(want);
  endtask

  always @(posedge clk) begin : watch
    qep_result_t want;
    if (!rst_n) begin
      cfg_mirror.min_limit      = 8'd0;
      cfg_mirror.max_limit      = 8'd255;
      cfg_mirror.ticks_per_step = 8'd4;
      prev_phase = '0;
      fwd_ticks  = '0;
      bwd_ticks  = '0;
      pos_track  = '0;
      expected_results.delete();
    end else begin
      // results leave before this edge's sample is predicted
      if (out_valid && !out_stall) begin
        samples_checked++;
        if (out_moved) steps_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result moved=%0b position=%0d",
                                    out_moved, out_position));
        end else begin
          want = expected_results.pop_front();
          if (out_moved !== want.moved) begin
            report_mismatch($sformatf("moved %0b, predicted %0b", out_moved, want.moved));
          end
          if (out_position !== want.position) begin
            report_mismatch($sformatf("position %0d, predicted %0d",
                                      out_position, want.position));
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MIN_LIMIT:      cfg_mirror.min_limit      = cfg_wdata;
          CFG_MAX_LIMIT:      cfg_mirror.max_limit      = cfg_wdata;
          CFG_TICKS_PER_STEP: cfg_mirror.ticks_per_step = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_sample({in_pin_b, in_pin_a});
    end
    outstanding <= expected_results.size();
  end

endmodule

// ===== tb/tb_quadrature_encoder_position_core.sv =====
`timescale 1ns / 100ps
module tb_quadrature_encoder_position_core;
  import qep_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on either channel
  localparam int HOLD_CYCLES    = 150;   // long result-side hold-off

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_pin_a  = 1'b0;
  logic                 in_pin_b  = 1'b0;
  logic                 out_stall = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_LIMIT;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 out_moved;
  logic [POS_W-1:0]     out_position;

  int fail_count;
  int outstanding;
  int samples_checked;
  int steps_seen;

  int send_idle_pct       = 0;
  int recv_stall_pct      = 0;
  int hold_gen            = 0;   // bumped by stimulus to request a hold-off
  int hold_gen_seen       = 0;
  int hold_left           = 0;
  int quiet_cycles        = 0;
  int backpressure_cycles = 0;
  int settings_run        = 0;

  // phase the block last saw, so random walks continue from it
  logic [PHASE_W-1:0] cur_phase = '0;

  // warm-up under reset config (ticks 4, limits 0..255): unchanged phase,
  // two forward steps, a repeat, two 2-bit jumps, then three backward steps
  // so the last one lands on the lower limit and still flags moved
  logic [PHASE_W-1:0] warmup_phases [24] = '{
    2'd0, 2'd2, 2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd1, 2'd0, 2'd0, 2'd3, 2'd0,
    2'd1, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3, 2'd2, 2'd0
  };

  always #5 clk = ~clk;

  quadrature_encoder_position_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pin_a     (in_pin_a),
    .in_pin_b     (in_pin_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_moved    (out_moved),
    .out_position (out_position),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  qep_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pin_a        (in_pin_a),
    .in_pin_b        (in_pin_b),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_moved       (out_moved),
    .out_position    (out_position),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .samples_checked (samples_checked),
    .steps_seen      (steps_seen)
  );

  // Result side: random stall, or a long hold-off when stimulus asks for one.
  // The hold is counted here so the sender keeps offering samples meanwhile
  // and the two-entry buffer fills until in_stall rises.
  always @(posedge clk) begin
    if (hold_gen != hold_gen_seen) begin
      hold_gen_seen <= hold_gen;
      hold_left     <= HOLD_CYCLES;
      out_stall     <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: no transaction on either channel for too long ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall) backpressure_cycles <= backpressure_cycles + 1;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // One sample transaction; valid stays up across back-to-back samples.
  task automatic drive_sample(input logic [PHASE_W-1:0] ph);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pin_a <= ph[0];
    in_pin_b <= ph[1];
    do @(posedge clk); while (in_stall);
    cur_phase = ph;
  endtask

  // Stop offering, wait for every predicted result, then let the pipe settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Mostly Gray runs in one direction with random length; some repeats and
  // some arbitrary phases (2-bit jumps, direction flips) as noise.
  task automatic encoder_walk(input int n_samples, input int max_run);
    int                 run_left;
    int                 roll;
    logic               going_fwd;
    logic [PHASE_W-1:0] nxt;
    run_left  = 0;
    going_fwd = 1'b1;
    for (int k = 0; k < n_samples; k++) begin
      if (run_left == 0) begin
        going_fwd = 1'($urandom_range(1));
        run_left  = $urandom_range(max_run, 1);
      end
      roll = $urandom_range(99);
      if (roll < 82) begin
        nxt = going_fwd ? {~cur_phase[0], cur_phase[1]} : {cur_phase[0], ~cur_phase[1]};
        run_left--;
      end else if (roll < 91) begin
        nxt = cur_phase;
      end else begin
        nxt = PHASE_W'($urandom_range(3));
      end
      drive_sample(nxt);
    end
  endtask

  task automatic run_setting(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                             input logic [CFG_W-1:0] ticks, input idle_mode_t mode,
                             input int n_samples, input int max_run, input bit with_hold);
    drain_results();
    cfg_write(CFG_MIN_LIMIT, lo);
    cfg_write(CFG_MAX_LIMIT, hi);
    cfg_write(CFG_TICKS_PER_STEP, ticks);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 55; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 55; end
      default:       begin send_idle_pct = 26; recv_stall_pct = 26; end
    endcase
    if (with_hold) hold_gen++;
    settings_run++;
    encoder_walk(n_samples, max_run);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (warmup_phases[i]) drive_sample(warmup_phases[i]);

    // limits, tick count, idling pattern, samples, longest run, hold-off
    run_setting(8'd0,   8'd255, 8'd4,   IDLE_NONE,     150, 12,  1'b0);
    run_setting(8'd10,  8'd20,  8'd1,   IDLE_SENDER,   150, 30,  1'b0);
    run_setting(8'd200, 8'd50,  8'd2,   IDLE_RECEIVER, 150, 20,  1'b0); // crossed limits
    run_setting(8'd0,   8'd0,   8'd3,   IDLE_BOTH,     100, 20,  1'b0); // pinned low
    run_setting(8'd255, 8'd255, 8'd1,   IDLE_BOTH,     100, 20,  1'b0); // pinned high
    run_setting(8'd0,   8'd255, 8'd0,   IDLE_SENDER,   500, 300, 1'b0); // 256-tick wrap
    run_setting(8'd5,   8'd250, 8'd255, IDLE_RECEIVER, 150, 300, 1'b0);
    // lowering ticks below the live counts forces them to wrap around
    run_setting(8'd5,   8'd250, 8'd3,   IDLE_NONE,     200, 25,  1'b1);
    run_setting(8'd128, 8'd127, 8'd1,   IDLE_BOTH,     150, 60,  1'b0);

    drain_results();
    repeat (5) @(posedge clk);

    $display("run: %0d samples checked, %0d position steps, %0d input back-pressure cycles",
             samples_checked, steps_seen, backpressure_cycles);
    $display("run: %0d limit/tick settings incl. crossed, pinned and zero-tick, plus hold-off",
             settings_run);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
